@@ sv/gesture_delta_repeat_trigger_top_defines.svh @@
// ----------------------------------------------------------------------------
// Gesture delta repeat trigger: assertion macros
// Shared assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef GESTURE_DELTA_REPEAT_TRIGGER_TOP_DEFINES_SVH
`define GESTURE_DELTA_REPEAT_TRIGGER_TOP_DEFINES_SVH

// same-cycle implication
`define GDRT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GDRT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/gdrt_pkg.sv @@
// ----------------------------------------------------------------------------
// Gesture delta repeat trigger: package
// Widths, codes, control word layout and the microcode table.
// ----------------------------------------------------------------------------
package gdrt_pkg;

  localparam int TOTAL_BITS  = 40;
  localparam int MAX_REPEATS = 16;
  localparam int CNT_W       = $clog2(MAX_REPEATS + 1);
  localparam int IDX_W       = (MAX_REPEATS > 1) ? $clog2(MAX_REPEATS) : 1;
  localparam int DELTA_W     = 32;
  localparam int THR_W       = 40;
  localparam int CMP_W       = (TOTAL_BITS > THR_W) ? TOTAL_BITS : THR_W;
  localparam int MODE_W      = 3;
  localparam int DIR_W       = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 40;
  localparam int STEP_W      = 3;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_END    = 2'd2,
    ACT_CANCEL = 2'd3
  } action_t;

  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_BEGIN      = 3'd0;
  localparam mode_t MODE_UPDATE     = 3'd1;
  localparam mode_t MODE_END        = 3'd2;
  localparam mode_t MODE_CANCEL     = 3'd3;
  localparam mode_t MODE_END_CANCEL = 3'd4;

  typedef logic [DIR_W-1:0] dir_t;
  localparam dir_t DIR_ANY = 2'd0;
  localparam dir_t DIR_NEG = 2'd1;
  localparam dir_t DIR_POS = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_FIRE_MODE    = 3'd0;
  localparam cfg_idx_t REG_INTERVAL     = 3'd1;
  localparam cfg_idx_t REG_DIRECTION    = 3'd2;
  localparam cfg_idx_t REG_THR_ENABLE   = 3'd3;
  localparam cfg_idx_t REG_THR_MIN      = 3'd4;
  localparam cfg_idx_t REG_THR_MAX      = 3'd5;

  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_WAIT      = 3'd0;
  localparam step_t STEP_ATT_START = 3'd1;
  localparam step_t STEP_CLEAR     = 3'd2;
  localparam step_t STEP_ACCUM     = 3'd3;
  localparam step_t STEP_ONCE      = 3'd4;
  localparam step_t STEP_REPEAT    = 3'd5;
  localparam step_t STEP_ATT_END   = 3'd6;
  localparam step_t STEP_EMIT      = 3'd7;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ATT_START,
    OP_CLEAR,
    OP_ACCUM,
    OP_ONCE,
    OP_REPEAT,
    OP_ATT_END,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_DISPATCH,
    BR_REPEAT_ON,
    BR_LOOP,
    BR_EMIT
  } br_t;

  typedef struct packed {
    op_t   op;
    br_t   br;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic    in_accept;
    action_t action;
    logic    repeat_on;
    logic    loop_go;
    logic    out_accept;
    logic    out_last;
  } status_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    case (s)
      STEP_WAIT:      w = '{op: OP_IDLE,      br: BR_DISPATCH,  target: STEP_WAIT};
      STEP_ATT_START: w = '{op: OP_ATT_START, br: BR_NEXT,      target: STEP_CLEAR};
      STEP_CLEAR:     w = '{op: OP_CLEAR,     br: BR_NEXT,      target: STEP_EMIT};
      STEP_ACCUM:     w = '{op: OP_ACCUM,     br: BR_NEXT,      target: STEP_ONCE};
      STEP_ONCE:      w = '{op: OP_ONCE,      br: BR_REPEAT_ON, target: STEP_EMIT};
      STEP_REPEAT:    w = '{op: OP_REPEAT,    br: BR_LOOP,      target: STEP_EMIT};
      STEP_ATT_END:   w = '{op: OP_ATT_END,   br: BR_NEXT,      target: STEP_CLEAR};
      STEP_EMIT:      w = '{op: OP_EMIT,      br: BR_EMIT,      target: STEP_WAIT};
      default:        w = '{op: OP_IDLE,      br: BR_DISPATCH,  target: STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(action_t a);
    step_t s;
    case (a)
      ACT_START:  s = STEP_ATT_START;
      ACT_UPDATE: s = STEP_ACCUM;
      default:    s = STEP_ATT_END;
    endcase
    return s;
  endfunction

endpackage

@@ sv/gdrt_if.sv @@
// ----------------------------------------------------------------------------
// Gesture delta repeat trigger: channel interfaces
// Event request, result request and register write channels.
// ----------------------------------------------------------------------------
interface gdrt_in_if;
  import gdrt_pkg::*;
  logic                       valid;
  logic                       ready;
  action_t                    action;
  logic signed [DELTA_W-1:0]  motion_delta;
  logic                       condition_ok;
  modport source (output valid, action, motion_delta, condition_ok, input ready);
  modport sink   (input valid, action, motion_delta, condition_ok, output ready);
endinterface

interface gdrt_out_if;
  logic valid;
  logic ready;
  logic fire;
  logic executed_flag;
  logic last;
  modport source (output valid, fire, executed_flag, last, input ready);
  modport sink   (input valid, fire, executed_flag, last, output ready);
endinterface

interface gdrt_cfg_if;
  import gdrt_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/gdrt_seq.sv @@
// ----------------------------------------------------------------------------
// Gesture delta repeat trigger: microcode sequencer
// Step counter over the control word table with conditional branches.
// ----------------------------------------------------------------------------
module gdrt_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  gdrt_pkg::status_t st,
  output gdrt_pkg::ctrl_t   ctrl
);
  import gdrt_pkg::*;

  step_t step_r;
  step_t step_nxt;

  assign ctrl = ucode(step_r);

  always_comb begin
    step_nxt = step_r;
    case (ctrl.br)
      BR_NEXT:      step_nxt = ctrl.target;
      BR_DISPATCH:  if (st.in_accept) step_nxt = dispatch(st.action);
      BR_REPEAT_ON: step_nxt = st.repeat_on ? step_t'(step_r + 1'b1) : ctrl.target;
      BR_LOOP:      if (!st.loop_go) step_nxt = ctrl.target;
      BR_EMIT:      if (st.out_accept && st.out_last) step_nxt = ctrl.target;
      default:      step_nxt = step_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ sv/gesture_delta_repeat_trigger_top.sv @@
// Start, end and cancel run an attempt step and a clear step, then the emit step.
// An update runs accumulate and once, then, with a repeat interval set, the repeat step
// while the total allows attempts, then emit. One control word runs per cycle, and the sequencer
// waits at the wait, repeat and emit steps and holds one request at a time.
// Reset: synchronous, active low; clears totals, executed flag and sequencer,
// and loads the register reset values.
// ----------------------------------------------------------------------------
// Gesture delta repeat trigger: top level
// Tracks gesture totals and emits one result per firing attempt, or one when none is made.
// ----------------------------------------------------------------------------
`include "gesture_delta_repeat_trigger_top_defines.svh"

module gesture_delta_repeat_trigger_top (
  input logic         clk,
  input logic         rst_n,
  gdrt_in_if.sink     in_ch,
  gdrt_out_if.source  out_ch,
  gdrt_cfg_if.sink    cfg_ch
);
  import gdrt_pkg::*;

  localparam logic signed [TOTAL_BITS-1:0] SMAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
  localparam logic signed [TOTAL_BITS-1:0] SMIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};

  function automatic logic dir_ok(dir_t d, logic neg, logic nz);
    logic r;
    case (d)
      DIR_ANY: r = 1'b1;
      DIR_NEG: r = neg;
      DIR_POS: r = !neg && nz;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  mode_t                      fire_mode_r;
  logic signed [DELTA_W-1:0]  interval_r;
  dir_t                       dir_r;
  logic                       thr_en_r;
  logic [THR_W-1:0]           thr_min_r;
  logic [THR_W-1:0]           thr_max_r;

  action_t                    action_r, action_nxt;
  logic signed [DELTA_W-1:0]  delta_r, delta_nxt;
  logic                       cond_r, cond_nxt;
  logic signed [TOTAL_BITS-1:0] total_r, total_nxt;
  logic [TOTAL_BITS-1:0]      abs_r, abs_nxt;
  logic                       exec_r, exec_nxt;
  logic [MAX_REPEATS-1:0]     fires_r, fires_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;

  ctrl_t   ctrl;
  status_t st;

  logic                          in_accept, out_accept;
  logic signed [TOTAL_BITS-1:0]  delta_ext, interval_ext, toward;
  logic [DELTA_W-1:0]            delta_mag, step_mag;
  logic [TOTAL_BITS-1:0]         total_mag;
  logic [TOTAL_BITS:0]           sum_s, sum_a;
  logic                          sum_ovf, may_fire, repeat_on, loop_go, attempt_en, hit;
  logic [CMP_W-1:0]              abs_cmp, min_cmp, max_cmp;

  gdrt_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctrl  (ctrl)
  );

  assign in_ch.ready   = (ctrl.op == OP_IDLE);
  assign in_accept     = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = (ctrl.op == OP_EMIT);
  assign out_accept    = out_ch.valid && out_ch.ready;
  assign out_ch.fire          = fires_r[0];
  assign out_ch.executed_flag = exec_r;
  assign out_ch.last          = (count_r <= CNT_W'(1));
  assign cfg_ch.ready  = 1'b1;

  assign delta_ext    = {{(TOTAL_BITS-DELTA_W){delta_r[DELTA_W-1]}}, delta_r};
  assign interval_ext = {{(TOTAL_BITS-DELTA_W){interval_r[DELTA_W-1]}}, interval_r};
  assign delta_mag    = delta_r[DELTA_W-1] ? (~delta_r + 1'b1) : delta_r;
  assign step_mag     = interval_r[DELTA_W-1] ? (~interval_r + 1'b1) : interval_r;
  assign total_mag    = total_r[TOTAL_BITS-1] ? (~total_r + 1'b1) : total_r;

  assign sum_s   = {total_r[TOTAL_BITS-1], total_r} + {delta_ext[TOTAL_BITS-1], delta_ext};
  assign sum_ovf = sum_s[TOTAL_BITS] != sum_s[TOTAL_BITS-1];
  assign sum_a   = {1'b0, abs_r} + {{(TOTAL_BITS+1-DELTA_W){1'b0}}, delta_mag};

  assign toward = (total_r[TOTAL_BITS-1] != interval_r[DELTA_W-1]) ?
                  (total_r + interval_ext) : (total_r - interval_ext);

  assign abs_cmp  = CMP_W'(abs_r);
  assign min_cmp  = CMP_W'(thr_min_r);
  assign max_cmp  = CMP_W'(thr_max_r);
  assign may_fire = cond_r && (!thr_en_r || (abs_cmp >= min_cmp && abs_cmp <= max_cmp));

  assign repeat_on = (fire_mode_r == MODE_UPDATE) && (interval_r != '0);
  assign loop_go   = (count_r < CNT_W'(MAX_REPEATS))
                     && dir_ok(dir_r, total_r[TOTAL_BITS-1], |total_r)
                     && (total_mag >= {{(TOTAL_BITS-DELTA_W){1'b0}}, step_mag});

  assign hit = (action_r == ACT_END) ?
               (fire_mode_r == MODE_END || fire_mode_r == MODE_END_CANCEL) :
               (fire_mode_r == MODE_CANCEL || fire_mode_r == MODE_END_CANCEL);

  assign st = '{in_accept:  in_accept,
                action:     in_ch.action,
                repeat_on:  repeat_on,
                loop_go:    loop_go,
                out_accept: out_accept,
                out_last:   out_ch.last};

  always_comb begin
    action_nxt = action_r;
    delta_nxt  = delta_r;
    cond_nxt   = cond_r;
    total_nxt  = total_r;
    abs_nxt    = abs_r;
    exec_nxt   = exec_r;
    fires_nxt  = fires_r;
    count_nxt  = count_r;
    attempt_en = 1'b0;
    case (ctrl.op)
      OP_IDLE: begin
        if (in_accept) begin
          action_nxt = in_ch.action;
          delta_nxt  = in_ch.motion_delta;
          cond_nxt   = in_ch.condition_ok;
          fires_nxt  = '0;
          count_nxt  = '0;
        end
      end
      OP_ATT_START: begin
        exec_nxt   = 1'b0;
        attempt_en = (fire_mode_r == MODE_BEGIN);
      end
      OP_CLEAR: begin
        if (action_r != ACT_START) exec_nxt = 1'b0;
        total_nxt = '0;
        abs_nxt   = '0;
      end
      OP_ACCUM: begin
        if (total_r[TOTAL_BITS-1] != delta_r[DELTA_W-1]) begin
          total_nxt = delta_ext;
        end else begin
          if (sum_ovf) begin
            total_nxt = delta_r[DELTA_W-1] ? SMIN : SMAX;
          end else begin
            total_nxt = sum_s[TOTAL_BITS-1:0];
          end
          abs_nxt = sum_a[TOTAL_BITS] ? {TOTAL_BITS{1'b1}} : sum_a[TOTAL_BITS-1:0];
        end
      end
      OP_ONCE: begin
        attempt_en = (fire_mode_r == MODE_UPDATE) && (interval_r == '0)
                     && dir_ok(dir_r, delta_r[DELTA_W-1], |delta_r);
      end
      OP_REPEAT: begin
        if (loop_go) begin
          attempt_en = 1'b1;
          total_nxt  = toward;
        end
      end
      OP_ATT_END: begin
        attempt_en = hit;
      end
      OP_EMIT: begin
        if (out_accept) begin
          fires_nxt = fires_r >> 1;
          if (count_r != '0) count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        attempt_en = 1'b0;
      end
    endcase
    if (attempt_en) begin
      if (may_fire) exec_nxt = 1'b1;
      if (count_r < CNT_W'(MAX_REPEATS)) begin
        fires_nxt[count_r[IDX_W-1:0]] = may_fire;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      abs_r   <= '0;
      exec_r  <= 1'b0;
      count_r <= '0;
    end else begin
      total_r <= total_nxt;
      abs_r   <= abs_nxt;
      exec_r  <= exec_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r <= action_nxt;
    delta_r  <= delta_nxt;
    cond_r   <= cond_nxt;
    fires_r  <= fires_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fire_mode_r <= MODE_UPDATE;
      interval_r  <= '0;
      dir_r       <= DIR_ANY;
      thr_en_r    <= 1'b0;
      thr_min_r   <= '0;
      thr_max_r   <= {THR_W{1'b1}};
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_FIRE_MODE:  fire_mode_r <= cfg_ch.data[MODE_W-1:0];
        REG_INTERVAL:   interval_r  <= cfg_ch.data[DELTA_W-1:0];
        REG_DIRECTION:  dir_r       <= cfg_ch.data[DIR_W-1:0];
        REG_THR_ENABLE: thr_en_r    <= cfg_ch.data[0];
        REG_THR_MIN:    thr_min_r   <= cfg_ch.data[THR_W-1:0];
        REG_THR_MAX:    thr_max_r   <= cfg_ch.data[THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  `GDRT_ASSERT_IMP(a_emit_blocks_input, out_ch.valid, !in_ch.ready, "input taken while emitting")
  `GDRT_ASSERT_NXT(a_last_returns_idle, out_accept && out_ch.last, in_ch.ready, "no return to wait after last result")
  `GDRT_ASSERT_IMP(a_repeat_capped, ctrl.op == OP_REPEAT && loop_go, count_r < CNT_W'(MAX_REPEATS), "repeat past cap")

endmodule

@@ test/gesture_delta_repeat_trigger_top_test.sv @@
// ----------------------------------------------------------------------------
// Gesture delta repeat trigger: self-checking testbench
// Runs directed and random gesture requests through several register
// settings. Predicts every result from its own copy of totals and registers,
// and compares each result in order. Both sides stall at random.
// ----------------------------------------------------------------------------
module gesture_delta_repeat_trigger_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gdrt_pkg::*;

  localparam mode_t MODE_UNUSED  = 3'd7;
  localparam dir_t  DIR_NONE     = 2'd3;
  localparam int    HOLD_CYCLES  = 300;
  localparam int    STALL_LIMIT  = 4000;
  localparam int    DRAIN_CYCLES = 40;
  localparam logic [THR_W-1:0] THR_ALL_ONES = '1;

  typedef struct {
    action_t            action;
    logic signed [31:0] delta;
    logic               cond;
  } gesture_req_t;

  typedef struct packed {
    logic fire;
    logic executed_flag;
    logic last;
  } trig_result_t;

  logic clk = 1'b0;
  logic rst_n;

  gdrt_in_if  in_ch ();
  gdrt_out_if out_ch ();
  gdrt_cfg_if cfg_ch ();

  gesture_delta_repeat_trigger_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  gesture_req_t gesture_reqs[$];
  trig_result_t trigger_results[$];

  // predicted block state and registers
  mode_t                          mode_cfg;
  logic signed [DELTA_W-1:0]      interval_cfg;
  dir_t                           dir_cfg;
  logic                           thr_en_cfg;
  logic [THR_W-1:0]               thr_min_cfg;
  logic [THR_W-1:0]               thr_max_cfg;
  logic signed [TOTAL_BITS-1:0]   dir_total;
  logic [TOTAL_BITS-1:0]          mag_total;
  logic                           executed;

  bit in_took;
  bit quiet;
  bit hold_phase;
  int hold_count;
  int in_gap;
  int out_gap;
  int mismatches;
  int stalled_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit direction_hit(longint v);
    case (dir_cfg)
      DIR_ANY: return 1'b1;
      DIR_NEG: return v < 0;
      DIR_POS: return v > 0;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit try_fire(bit cond);
    bit ok;
    ok = cond;
    if (thr_en_cfg && (mag_total < thr_min_cfg || mag_total > thr_max_cfg)) ok = 1'b0;
    if (ok) executed = 1'b1;
    return ok;
  endfunction

  function automatic void predict_trigger(gesture_req_t req);
    bit     fires[$];
    longint st;
    longint d;
    longint iv;
    longint step_mag;
    longint ab;
    longint smax;
    longint smin;
    longint umax;
    int     n;
    smax = (longint'(1) <<< (TOTAL_BITS - 1)) - 1;
    smin = -smax - 1;
    umax = (longint'(1) <<< TOTAL_BITS) - 1;
    st = longint'(dir_total);
    d  = longint'(req.delta);
    iv = longint'(interval_cfg);
    case (req.action)
      ACT_START: begin
        executed = 1'b0;
        if (mode_cfg == MODE_BEGIN) fires.push_back(try_fire(req.cond));
        dir_total = '0;
        mag_total = '0;
      end
      ACT_UPDATE: begin
        if ((st < 0) != (d < 0)) begin
          st = d;
        end else begin
          if (d > 0 && st > smax - d) st = smax;
          else if (d < 0 && st < smin - d) st = smin;
          else st = st + d;
          ab = longint'(mag_total) + (d < 0 ? -d : d);
          if (ab > umax) ab = umax;
          mag_total = ab[TOTAL_BITS-1:0];
        end
        if (mode_cfg == MODE_UPDATE) begin
          if (iv == 0) begin
            if (direction_hit(d)) fires.push_back(try_fire(req.cond));
          end else begin
            step_mag = iv < 0 ? -iv : iv;
            while (fires.size() < MAX_REPEATS && direction_hit(st) &&
                   (st < 0 ? -st : st) >= step_mag) begin
              fires.push_back(try_fire(req.cond));
              if ((st < 0) != (iv < 0)) st = st + iv;
              else st = st - iv;
            end
          end
        end
        dir_total = st[TOTAL_BITS-1:0];
      end
      default: begin
        if ((req.action == ACT_END &&
             (mode_cfg == MODE_END || mode_cfg == MODE_END_CANCEL)) ||
            (req.action == ACT_CANCEL &&
             (mode_cfg == MODE_CANCEL || mode_cfg == MODE_END_CANCEL)))
          fires.push_back(try_fire(req.cond));
        executed  = 1'b0;
        dir_total = '0;
        mag_total = '0;
      end
    endcase
    if (fires.size() == 0) fires.push_back(1'b0);
    n = fires.size();
    for (int k = 0; k < n; k++)
      trigger_results.push_back('{fire: fires[k], executed_flag: executed, last: k == n - 1});
  endfunction

  // sample all three channels
  always @(posedge clk) begin
    gesture_req_t req;
    trig_result_t got;
    trig_result_t want;
    if (rst_n) begin
      in_took = in_ch.valid && in_ch.ready;
      if (in_took) begin
        req.action = in_ch.action;
        req.delta  = in_ch.motion_delta;
        req.cond   = in_ch.condition_ok;
        predict_trigger(req);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_FIRE_MODE:  mode_cfg     = cfg_ch.data[MODE_W-1:0];
          REG_INTERVAL:   interval_cfg = cfg_ch.data[DELTA_W-1:0];
          REG_DIRECTION:  dir_cfg      = cfg_ch.data[DIR_W-1:0];
          REG_THR_ENABLE: thr_en_cfg   = cfg_ch.data[0];
          REG_THR_MIN:    thr_min_cfg  = cfg_ch.data[THR_W-1:0];
          REG_THR_MAX:    thr_max_cfg  = cfg_ch.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{fire: out_ch.fire, executed_flag: out_ch.executed_flag, last: out_ch.last};
        if (trigger_results.size() == 0) begin
          if (mismatches < 20)
            $display("%0t: unexpected result fire %0b flag %0b last %0b", $time,
                     got.fire, got.executed_flag, got.last);
          mismatches++;
        end else begin
          want = trigger_results.pop_front();
          if (got.fire !== want.fire || got.executed_flag !== want.executed_flag ||
              got.last !== want.last) begin
            if (mismatches < 20)
              $display("%0t: result mismatch: expected fire %0b flag %0b last %0b, got fire %0b flag %0b last %0b",
                       $time, want.fire, want.executed_flag, want.last,
                       got.fire, got.executed_flag, got.last);
            mismatches++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("gesture_delta_repeat_trigger_top_test failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  // request driver: hold until taken, then advance
  always @(negedge clk) begin
    gesture_req_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (!quiet && !hold_phase && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 10);
        in_ch.valid <= 1'b0;
      end else if (gesture_reqs.size() > 0) begin
        req = gesture_reqs.pop_front();
        in_ch.action       <= req.action;
        in_ch.motion_delta <= req.delta;
        in_ch.condition_ok <= req.cond;
        in_ch.valid        <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_phase && hold_count < HOLD_CYCLES) begin
      hold_count++;
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 10);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic queue_req(action_t a, logic [31:0] d, logic c);
    gesture_reqs.push_back('{action: a, delta: d, cond: c});
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (gesture_reqs.size() != 0 || in_ch.valid || trigger_results.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(mode_t m, logic [31:0] iv, dir_t dir, logic en,
                           logic [THR_W-1:0] lo, logic [THR_W-1:0] hi);
    wait_drained();
    write_reg(REG_FIRE_MODE, CFG_DATA_W'(m));
    write_reg(REG_INTERVAL, CFG_DATA_W'(iv));
    write_reg(REG_DIRECTION, CFG_DATA_W'(dir));
    write_reg(REG_THR_ENABLE, CFG_DATA_W'(en));
    write_reg(REG_THR_MIN, CFG_DATA_W'(lo));
    write_reg(REG_THR_MAX, CFG_DATA_W'(hi));
  endtask

  function automatic logic [THR_W-1:0] pick_bound(logic [THR_W-1:0] base);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return THR_ALL_ONES;
      2: return {8'($urandom_range(0, 255)), 32'($urandom())};
      default: return base + THR_W'($urandom_range(0, 32'h30_0000));
    endcase
  endfunction

  task automatic configure_random();
    mode_t            m;
    logic [31:0]      iv;
    logic [THR_W-1:0] lo;
    m = ($urandom_range(0, 9) < 4) ? mode_t'($urandom_range(0, 7)) : MODE_UPDATE;
    case ($urandom_range(0, 7))
      0: iv = '0;
      1: iv = 32'h8000_0000;
      2: iv = 32'h7FFF_FFFF;
      3: iv = $urandom();
      4: iv = -$urandom_range(1, 32'h3_0000);
      default: iv = $urandom_range(32'h4000, 32'h3_0000);
    endcase
    lo = pick_bound('0);
    configure(m, iv, dir_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), lo,
              pick_bound(lo));
  endtask

  function automatic logic [31:0] pick_delta(bit neg);
    logic [31:0] m;
    case ($urandom_range(0, 9))
      0: m = '0;
      1: return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      2: return $urandom();
      default: m = $urandom_range(1, 32'h6_0000);
    endcase
    return neg ? -m : m;
  endfunction

  function automatic logic pick_cond();
    return $urandom_range(0, 6) != 0;
  endfunction

  // mostly whole gestures; some with start or end dropped, some stray requests
  task automatic queue_gestures(int n_items);
    int sent;
    int pick;
    int n_upd;
    bit neg;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        queue_req(action_t'($urandom_range(0, 3)), $urandom(), pick_cond());
        sent++;
      end else begin
        if (pick != 1) begin
          queue_req(ACT_START, $urandom(), pick_cond());
          sent++;
        end
        n_upd = $urandom_range(1, 8);
        neg = 1'($urandom_range(0, 1));
        repeat (n_upd) begin
          queue_req(ACT_UPDATE, pick_delta(neg ^ ($urandom_range(0, 4) == 0)), pick_cond());
        end
        sent += n_upd;
        if (pick != 2) begin
          queue_req($urandom_range(0, 1) ? ACT_END : ACT_CANCEL, $urandom(), pick_cond());
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_START;
    in_ch.motion_delta = '0;
    in_ch.condition_ok = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_FIRE_MODE;
    cfg_ch.data = '0;
    mode_cfg = MODE_UPDATE;
    interval_cfg = '0;
    dir_cfg = DIR_ANY;
    thr_en_cfg = 1'b0;
    thr_min_cfg = '0;
    thr_max_cfg = THR_ALL_ONES;
    dir_total = '0;
    mag_total = '0;
    executed = 1'b0;
    in_took = 1'b0;
    quiet = 1'b0;
    hold_phase = 1'b0;
    hold_count = 0;
    in_gap = 0;
    out_gap = 0;
    mismatches = 0;
    stalled_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register defaults: update mode, once per delta
    queue_req(ACT_START, '0, 1'b1);
    queue_req(ACT_UPDATE, 32'h7FFF_FFFF, 1'b1);
    queue_req(ACT_UPDATE, 32'h8000_0000, 1'b1);
    queue_req(ACT_UPDATE, '0, 1'b0);
    queue_req(ACT_END, '0, 1'b1);
    queue_req(ACT_CANCEL, '1, 1'b1);

    configure(MODE_BEGIN, '0, DIR_ANY, 1'b0, '0, THR_ALL_ONES);
    queue_req(ACT_START, '0, 1'b1);
    queue_req(ACT_START, '0, 1'b0);

    configure(MODE_END_CANCEL, '0, DIR_ANY, 1'b1, '0, '0);
    queue_req(ACT_START, '0, 1'b1);
    queue_req(ACT_END, '0, 1'b1);
    queue_req(ACT_UPDATE, 32'h0001_0000, 1'b1);
    queue_req(ACT_CANCEL, '0, 1'b1);

    // repeat cap with carry into the next update, then a mismatched direction
    configure(MODE_UPDATE, 32'h0001_0000, DIR_POS, 1'b0, '0, THR_ALL_ONES);
    queue_req(ACT_START, '0, 1'b1);
    queue_req(ACT_UPDATE, 32'h0014_0000, 1'b1);
    queue_req(ACT_UPDATE, '0, 1'b1);
    queue_req(ACT_UPDATE, -32'sh0002_8000, 1'b1);

    configure(MODE_UPDATE, 32'h8000_0000, DIR_NEG, 1'b0, '0, THR_ALL_ONES);
    queue_req(ACT_UPDATE, 32'h8000_0000, 1'b1);

    configure(MODE_UNUSED, '0, DIR_ANY, 1'b0, '0, THR_ALL_ONES);
    queue_req(ACT_START, '0, 1'b1);
    queue_req(ACT_UPDATE, 32'h0001_0000, 1'b1);
    queue_req(ACT_END, '0, 1'b1);

    configure(MODE_UPDATE, '0, DIR_NONE, 1'b0, '0, THR_ALL_ONES);
    queue_req(ACT_UPDATE, 32'h0001_0000, 1'b1);

    // empty threshold range
    configure(MODE_UPDATE, '0, DIR_ANY, 1'b1, THR_ALL_ONES, '0);
    queue_req(ACT_UPDATE, 32'h0000_0001, 1'b1);

    configure(MODE_END, '0, DIR_ANY, 1'b0, '0, THR_ALL_ONES);
    queue_req(ACT_END, '0, 1'b1);

    configure(MODE_CANCEL, '0, DIR_ANY, 1'b0, '0, THR_ALL_ONES);
    queue_req(ACT_CANCEL, '0, 1'b1);

    for (int p = 0; p < 6; p++) begin
      configure_random();
      if (p == 1) hold_phase = 1'b1;
      queue_gestures(45);
    end

    configure(MODE_UPDATE, 32'h0000_8000, DIR_ANY, 1'b0, '0, THR_ALL_ONES);
    quiet = 1'b1;
    queue_gestures(40);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && trigger_results.size() == 0)
      $display("gesture_delta_repeat_trigger_top_test passed");
    else
      $display("gesture_delta_repeat_trigger_top_test failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/gdrt_pkg.sv
sv/gdrt_if.sv
sv/gdrt_seq.sv
sv/gesture_delta_repeat_trigger_top.sv
test/gesture_delta_repeat_trigger_top_test.sv
